/* design/ray_box_slab_intersect_assert.svh */
// Assertion macros shared by the ray/box slab test RTL.
`ifndef RAY_BOX_SLAB_INTERSECT_ASSERT_SVH
`define RAY_BOX_SLAB_INTERSECT_ASSERT_SVH

// Clocked assertion, disabled while reset is asserted.
`define RBSI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same check, reported with a fixed message.
`define RBSI_CHECK(lbl, prop) \
  `RBSI_ASSERT(lbl, prop, "ray box slab check failed")

`endif

/* design/rbsi_pkg.sv */
// Package: widths, constants and payload types of the ray/box slab test.
package rbsi_pkg;

  localparam int CW = 32;            // coordinate width
  localparam int FB = 16;            // fraction bits
  localparam int DW = CW + 1;        // exact difference width
  localparam int NW = DW + FB;       // dividend width, one quotient bit per stage
  localparam int LAT = NW + 3;       // input register to output register

  localparam logic signed [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

  typedef struct packed {
    logic signed [CW-1:0] origin_x;
    logic signed [CW-1:0] origin_y;
    logic signed [CW-1:0] origin_z;
    logic signed [CW-1:0] dir_x;
    logic signed [CW-1:0] dir_y;
    logic signed [CW-1:0] dir_z;
    logic signed [CW-1:0] box_min_x;
    logic signed [CW-1:0] box_min_y;
    logic signed [CW-1:0] box_min_z;
    logic signed [CW-1:0] box_max_x;
    logic signed [CW-1:0] box_max_y;
    logic signed [CW-1:0] box_max_z;
  } in_t;

  typedef struct packed {
    logic                 hit;
    logic signed [CW-1:0] entry_distance;
  } out_t;

  // Per-axis result handed from a lane to the merge stage.
  typedef struct packed {
    logic                 ok;
    logic signed [CW-1:0] ts;
    logic signed [CW-1:0] tb;
  } lane_res_t;

endpackage

/* design/rbsi_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
module rbsi_div import rbsi_pkg::*; (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic          num_neg_i,
  input  logic [DW-1:0] num_mag_i,
  input  logic          den_neg_i,
  input  logic [CW-1:0] den_mag_i,
  output logic [NW-1:0] quot_o,
  output logic          quot_neg_o
);

  logic [CW-1:0] rem_q  [NW+1];
  logic [NW-1:0] quot_q [NW+1];
  logic [NW-1:0] num_q  [NW+1];
  logic [CW-1:0] den_q  [NW+1];
  logic          neg_q  [NW+1];

  // Load stage: dividend is the magnitude shifted up by the fraction bits
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= '0;
      quot_q[0] <= '0;
      num_q[0]  <= NW'(num_mag_i) << FB;
      den_q[0]  <= den_mag_i;
      neg_q[0]  <= num_neg_i ^ den_neg_i;
    end
  end

  // Shift-subtract stages
  for (genvar k = 1; k <= NW; k++) begin : g_stage
    logic [CW:0] trial;
    logic [CW:0] sub;
    logic        ge;
    assign trial = {rem_q[k-1], num_q[k-1][NW-1]};
    assign sub   = trial - {1'b0, den_q[k-1]};
    assign ge    = trial >= {1'b0, den_q[k-1]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? sub[CW-1:0] : trial[CW-1:0];
        quot_q[k] <= {quot_q[k-1][NW-2:0], ge};
        num_q[k]  <= num_q[k-1] << 1;
        den_q[k]  <= den_q[k-1];
        neg_q[k]  <= neg_q[k-1];
      end
    end
  end

  assign quot_o     = quot_q[NW];
  assign quot_neg_o = neg_q[NW];

endmodule

/* design/rbsi_lane.sv */
// One axis lane: slab distances, saturation and ordering.
module rbsi_lane import rbsi_pkg::*; (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [CW-1:0] org_i,
  input  logic signed [CW-1:0] dir_i,
  input  logic signed [CW-1:0] lo_i,
  input  logic signed [CW-1:0] hi_i,
  output lane_res_t            res_o
);

  logic signed [DW-1:0] diff_lo, diff_hi;
  logic [DW-1:0]        mag_lo, mag_hi;
  logic [CW-1:0]        den_mag;
  logic                 par, in_slab;
  logic [NW-1:0]        q_lo, q_hi;
  logic                 qn_lo, qn_hi;
  logic [1:0]           side_q [NW+1];
  logic signed [CW-1:0] t0, t1;
  lane_res_t            res_d, res_q;

  // Exact differences and magnitudes
  assign diff_lo = {lo_i[CW-1], lo_i} - {org_i[CW-1], org_i};
  assign diff_hi = {hi_i[CW-1], hi_i} - {org_i[CW-1], org_i};
  assign mag_lo  = diff_lo[DW-1] ? DW'(-diff_lo) : DW'(diff_lo);
  assign mag_hi  = diff_hi[DW-1] ? DW'(-diff_hi) : DW'(diff_hi);
  assign den_mag = dir_i[CW-1] ? CW'(-dir_i) : CW'(dir_i);
  assign par     = (dir_i == '0);
  assign in_slab = (lo_i <= org_i) && (org_i <= hi_i);

  rbsi_div u_div_lo (
    .clk_i, .en_i,
    .num_neg_i (diff_lo[DW-1]), .num_mag_i (mag_lo),
    .den_neg_i (dir_i[CW-1]),   .den_mag_i (den_mag),
    .quot_o    (q_lo),          .quot_neg_o (qn_lo)
  );

  rbsi_div u_div_hi (
    .clk_i, .en_i,
    .num_neg_i (diff_hi[DW-1]), .num_mag_i (mag_hi),
    .den_neg_i (dir_i[CW-1]),   .den_mag_i (den_mag),
    .quot_o    (q_hi),          .quot_neg_o (qn_hi)
  );

  // Parallel-axis flags ride alongside the divider
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= {par, in_slab};
      for (int k = 1; k <= NW; k++) side_q[k] <= side_q[k-1];
    end
  end

  // Saturate a quotient magnitude into the signed coordinate range
  function automatic logic signed [CW-1:0] sat(input logic [NW-1:0] q, input logic n);
    logic neg;
    neg = n && (q != '0);
    if (!neg) sat = (q > NW'(MAXV)) ? MAXV : q[CW-1:0];
    else      sat = (q[NW-1:CW-1] != '0) ? MINV : CW'(-q[CW-1:0]);
  endfunction

  assign t0 = sat(q_lo, qn_lo);
  assign t1 = sat(q_hi, qn_hi);

  // Order the pair, or flag a parallel axis
  always_comb begin
    res_d.ok = 1'b1;
    res_d.ts = (t0 < t1) ? t0 : t1;
    res_d.tb = (t0 < t1) ? t1 : t0;
    if (side_q[NW][1]) begin
      res_d.ok = side_q[NW][0];
      res_d.ts = MINV;
      res_d.tb = MAXV;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

/* design/ray_box_slab_intersect.sv */
// Top level: ray versus axis-aligned box slab test, three lanes and a merge.
//
// Input channel in_valid_i/in_ready_o carries one ray and box per transaction
// (signed Q16.16 fields); output channel out_valid_o/out_ready_i returns the
// hit flag and the entry distance (largest positive value on a miss).
// One transaction is taken every cycle while the output side keeps up.
// The path from acceptance to output valid runs through one load register,
// 49 divider stages (one quotient bit each), a saturate/order register per
// lane and the merge output register.
// Each of the three lanes runs two pipelined dividers, one per slab plane.
// The whole pipeline advances together; while the output holds an untaken
// result, ready drops and every stage freezes, so nothing is lost.
// Reset clears the valid pipeline; the block is ready right after reset.
// The block holds no state between transactions.
module ray_box_slab_intersect import rbsi_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  `include "ray_box_slab_intersect_assert.svh"

  logic                 en;
  logic [LAT-1:0]       vld_q, vld_d;
  lane_res_t            res [3];
  logic signed [CW-1:0] entry, exitd;
  out_t                 out_d, out_q;

  assign en         = !vld_q[LAT-1] || out_ready_i;
  assign in_ready_o = en;

  // Lanes, one per axis
  rbsi_lane u_lane_x (.clk_i, .en_i(en), .org_i(in_data_i.origin_x),
    .dir_i(in_data_i.dir_x), .lo_i(in_data_i.box_min_x), .hi_i(in_data_i.box_max_x),
    .res_o(res[0]));
  rbsi_lane u_lane_y (.clk_i, .en_i(en), .org_i(in_data_i.origin_y),
    .dir_i(in_data_i.dir_y), .lo_i(in_data_i.box_min_y), .hi_i(in_data_i.box_max_y),
    .res_o(res[1]));
  rbsi_lane u_lane_z (.clk_i, .en_i(en), .org_i(in_data_i.origin_z),
    .dir_i(in_data_i.dir_z), .lo_i(in_data_i.box_min_z), .hi_i(in_data_i.box_max_z),
    .res_o(res[2]));

  // Merge: latest entry, earliest exit
  always_comb begin
    entry = MINV;
    exitd = MAXV;
    for (int a = 0; a < 3; a++) begin
      if (res[a].ts > entry) entry = res[a].ts;
      if (res[a].tb < exitd) exitd = res[a].tb;
    end
    if (res[0].ok && res[1].ok && res[2].ok && (entry < exitd)) begin
      out_d.hit            = 1'b1;
      out_d.entry_distance = entry;
    end else begin
      out_d.hit            = 1'b0;
      out_d.entry_distance = MAXV;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) out_q <= out_d;
  end

  // Valid pipeline
  assign vld_d = {vld_q[LAT-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  assign out_valid_o = vld_q[LAT-1];
  assign out_data_o  = out_q;

  `RBSI_CHECK(a_ready_rule, in_ready_o == (!out_valid_o || out_ready_i))
  `RBSI_CHECK(a_miss_max, out_valid_o && !out_data_o.hit |-> out_data_o.entry_distance == MAXV)
  `RBSI_ASSERT(a_hit_below_max, out_valid_o && out_data_o.hit |-> out_data_o.entry_distance != MAXV, "hit with maximum distance")

endmodule
